// File: src/htbd_pkg.sv
// ----------------------------------------------------------------------------
// Huffman tree bit decoder package
// Shared widths, codes and the result word type of the tree-walk decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package htbd_pkg;

   localparam int IDX_FIELD_W      = 9;
   localparam int SYMBOL_W         = 8;
   localparam int NODES_DEFAULT    = 512;
   localparam int SYMBOL_BITS_DEF  = 8;
   localparam int FOLD_SHIFT       = 20;
   localparam int RSP_DEPTH        = 3;
   localparam int RSP_PTR_W        = 2;
   localparam int RSP_COUNT_W      = 2;
   localparam int CSR_ADDR_W       = 3;
   localparam int CSR_DATA_W       = 32;

   localparam logic [0:0] CSR_ROOT_NODE = 1'b0;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ERROR = 1'b1;

   typedef enum logic [0:0] {
      OP_WRITE  = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   typedef struct packed {
      logic [SYMBOL_W-1:0] symbol;
      logic                status;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: src/htbd_rsp_queue.sv
// ----------------------------------------------------------------------------
// Result queue
// Three-word circular queue that holds decoded words until the receiver
// takes them, so the decode walk keeps moving while the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module htbd_rsp_queue (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push_valid,
   input  wire htbd_pkg::rsp_word_type                push_word,
   input  wire logic                                  pop_stall,
   output logic                                       pop_valid,
   output htbd_pkg::rsp_word_type                     pop_word,
   output logic [htbd_pkg::RSP_COUNT_W-1:0]           count
);

   localparam int DEPTH = htbd_pkg::RSP_DEPTH;
   localparam int PTR_W = htbd_pkg::RSP_PTR_W;
   localparam int CNT_W = htbd_pkg::RSP_COUNT_W;

   htbd_pkg::rsp_word_type slots [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             pop;

   assign pop       = (count_ff != '0) && !pop_stall;
   assign pop_valid = (count_ff != '0);
   assign pop_word  = slots[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slots[wr_ptr_ff] <= push_word;
      end
   end

endmodule

`default_nettype wire

// File: src/huffman_tree_bit_decoder_unit.sv
// ----------------------------------------------------------------------------
// Huffman tree bit decoder
// Walks a code tree held in a synchronous node table, one code bit per word.
// ----------------------------------------------------------------------------
// Usage: a request word with operation write loads one node table entry; a
// request word with operation decode moves the walk by one code bit. A
// decode word that reaches a leaf produces a response word with the leaf
// symbol; a last bit that ends off a leaf, or a walk standing on a leaf,
// produces an error response word. The root index is set through the CSR
// port.
// Throughput is one request word per cycle while req_stall is low, set by the node table read:
// the child index of the next word comes from the entry read in the cycle
// before. A response word is valid on the response channel once its result
// has passed the node table read and been written into the response queue.
// A write of the root register stalls the request channel while the new
// root entry is read.
// Reset puts the walk at node 0, clears the root register and empties the
// response queue; the node table keeps its contents and must be written
// before use. A stalled response channel fills a three-word queue; the
// request channel stalls once the queue and the word in flight could fill it.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_tree_bit_decoder_unit #(
   parameter int NODES       = htbd_pkg::NODES_DEFAULT,
   parameter int SYMBOL_BITS = htbd_pkg::SYMBOL_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_operation,
   input  wire logic [htbd_pkg::IDX_FIELD_W-1:0]     req_node_index,
   input  wire logic [htbd_pkg::IDX_FIELD_W-1:0]     req_left_child,
   input  wire logic [htbd_pkg::IDX_FIELD_W-1:0]     req_right_child,
   input  wire logic                                 req_leaf_flag,
   input  wire logic [htbd_pkg::SYMBOL_W-1:0]        req_leaf_symbol,
   input  wire logic                                 req_code_bit,
   input  wire logic                                 req_last_bit,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [htbd_pkg::SYMBOL_W-1:0]             rsp_symbol,
   output logic                                      rsp_status,
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [htbd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic [htbd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [htbd_pkg::CSR_DATA_W-1:0]           csr_prdata,
   output logic                                      csr_pready
);

   localparam int IDX_W    = $clog2(NODES);
   localparam int FIELD_W  = htbd_pkg::IDX_FIELD_W;
   localparam int SYM_W    = htbd_pkg::SYMBOL_W;
   localparam int SHIFT    = htbd_pkg::FOLD_SHIFT;
   localparam int MUL_W    = SHIFT + 1;
   localparam int PROD_W   = FIELD_W + MUL_W;
   localparam int FOLD_MUL = (2 ** SHIFT + NODES - 1) / NODES;
   localparam int CNT_W    = htbd_pkg::RSP_COUNT_W;

   typedef struct packed {
      logic [IDX_W-1:0]       left;
      logic [IDX_W-1:0]       right;
      logic                   leaf;
      logic [SYMBOL_BITS-1:0] symbol;
   } node_type;

   function automatic logic [IDX_W-1:0] fold_index(input logic [FIELD_W-1:0] value);
      logic [PROD_W-1:0]       prod;
      logic [PROD_W-SHIFT-1:0] quot;
      logic [PROD_W-1:0]       back;
      logic [PROD_W-1:0]       rem;
      prod = PROD_W'(value) * PROD_W'(MUL_W'(FOLD_MUL));
      quot = prod[PROD_W-1:SHIFT];
      back = PROD_W'(quot) * PROD_W'(NODES);
      rem  = PROD_W'(value) - back;
      return rem[IDX_W-1:0];
   endfunction

   node_type node_mem [NODES];
   node_type rd_node_ff;

   logic                   req_accept, wr_en, dec_en, csr_wr_root;
   logic [IDX_W-1:0]       wr_idx, child_idx, rd_addr, eff_idx;
   logic [SYMBOL_BITS-1:0] wr_sym;
   logic [SYM_W-1:0]       leaf_sym;
   node_type               wr_node, eff_node;
   logic                   res_push;
   htbd_pkg::rsp_word_type res_word, q_word;
   logic [CNT_W-1:0]       q_count;

   logic [IDX_W-1:0]       cur_idx_ff,  cur_idx_in;
   node_type               cur_ent_ff,  cur_ent_in;
   node_type               root_ent_ff, root_ent_in;
   logic [FIELD_W-1:0]     root_node_ff, root_node_in;
   logic [IDX_W-1:0]       root_idx_ff, root_idx_in;
   logic                   p_valid_ff,  p_valid_in;
   logic [IDX_W-1:0]       p_idx_ff,    p_idx_in;
   logic                   p_cur_leaf_ff, p_cur_leaf_in;
   logic                   p_last_ff,   p_last_in;
   logic                   refresh_ff,  refresh_in;
   logic                   load_ff,     load_in;

   for (genvar i = 0; i < SYMBOL_BITS; i++) begin : g_sym_in
      if (i < SYM_W) begin : g_bit
         assign wr_sym[i] = req_leaf_symbol[i];
      end else begin : g_pad
         assign wr_sym[i] = 1'b0;
      end
   end

   for (genvar i = 0; i < SYM_W; i++) begin : g_sym_out
      if (i < SYMBOL_BITS) begin : g_bit
         assign leaf_sym[i] = rd_node_ff.symbol[i];
      end else begin : g_pad
         assign leaf_sym[i] = 1'b0;
      end
   end

   assign req_stall  = refresh_ff ||
                       ((CNT_W + 1)'(q_count) + (CNT_W + 1)'(p_valid_ff) >=
                        (CNT_W + 1)'(htbd_pkg::RSP_DEPTH));
   assign req_accept = req_valid && !req_stall;
   assign wr_en      = req_accept && (req_operation == htbd_pkg::OP_WRITE);
   assign dec_en     = req_accept && (req_operation == htbd_pkg::OP_DECODE);

   assign wr_idx         = fold_index(req_node_index);
   assign wr_node.left   = fold_index(req_left_child);
   assign wr_node.right  = fold_index(req_right_child);
   assign wr_node.leaf   = req_leaf_flag;
   assign wr_node.symbol = wr_sym;

   assign csr_pready  = 1'b1;
   assign csr_wr_root = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                        (csr_paddr[2:2] == htbd_pkg::CSR_ROOT_NODE);
   assign csr_prdata  = (csr_paddr[2:2] == htbd_pkg::CSR_ROOT_NODE) ?
                        htbd_pkg::CSR_DATA_W'(root_node_ff) : '0;

   always_comb begin
      res_push        = 1'b0;
      res_word.symbol = '0;
      res_word.status = htbd_pkg::STATUS_ERROR;
      eff_idx         = cur_idx_ff;
      eff_node        = cur_ent_ff;
      if (p_valid_ff) begin
         if (p_cur_leaf_ff || rd_node_ff.leaf || p_last_ff) begin
            res_push = 1'b1;
            eff_idx  = root_idx_ff;
            eff_node = root_ent_ff;
            if (!p_cur_leaf_ff && rd_node_ff.leaf) begin
               res_word.symbol = leaf_sym;
               res_word.status = htbd_pkg::STATUS_OK;
            end
         end else begin
            eff_idx  = p_idx_ff;
            eff_node = rd_node_ff;
         end
      end
   end

   assign child_idx = req_code_bit ? eff_node.right : eff_node.left;
   assign rd_addr   = refresh_ff ? root_idx_ff : child_idx;

   always_comb begin
      cur_idx_in    = eff_idx;
      cur_ent_in    = (wr_en && (wr_idx == eff_idx)) ? wr_node : eff_node;
      p_valid_in    = dec_en;
      p_idx_in      = child_idx;
      p_cur_leaf_in = eff_node.leaf;
      p_last_in     = req_last_bit;
      root_node_in  = root_node_ff;
      root_idx_in   = root_idx_ff;
      refresh_in    = csr_wr_root;
      load_in       = refresh_ff;
      if (csr_wr_root) begin
         root_node_in = csr_pwdata[FIELD_W-1:0];
         root_idx_in  = fold_index(csr_pwdata[FIELD_W-1:0]);
      end
      if (wr_en && (wr_idx == root_idx_ff)) begin
         root_ent_in = wr_node;
      end else if (load_ff) begin
         root_ent_in = rd_node_ff;
      end else begin
         root_ent_in = root_ent_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_idx_ff   <= '0;
         cur_ent_ff   <= '0;
         root_ent_ff  <= '0;
         root_node_ff <= '0;
         root_idx_ff  <= '0;
         p_valid_ff   <= 1'b0;
         refresh_ff   <= 1'b0;
         load_ff      <= 1'b0;
      end else begin
         cur_idx_ff   <= cur_idx_in;
         cur_ent_ff   <= cur_ent_in;
         root_ent_ff  <= root_ent_in;
         root_node_ff <= root_node_in;
         root_idx_ff  <= root_idx_in;
         p_valid_ff   <= p_valid_in;
         refresh_ff   <= refresh_in;
         load_ff      <= load_in;
      end
   end

   always_ff @(posedge clock) begin
      p_idx_ff      <= p_idx_in;
      p_cur_leaf_ff <= p_cur_leaf_in;
      p_last_ff     <= p_last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_idx] <= wr_node;
      end
      rd_node_ff <= node_mem[rd_addr];
   end

   htbd_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (res_push),
      .push_word  (res_word),
      .pop_stall  (rsp_stall),
      .pop_valid  (rsp_valid),
      .pop_word   (q_word),
      .count      (q_count)
   );

   assign rsp_symbol = q_word.symbol;
   assign rsp_status = q_word.status;

   a_queue_room : assert property (@(posedge clock) disable iff (reset)
      res_push |-> (q_count < CNT_W'(htbd_pkg::RSP_DEPTH)))
      else $error("result pushed into a full response queue");

   a_result_follows_decode : assert property (@(posedge clock) disable iff (reset)
      res_push |-> $past(dec_en))
      else $error("result without a decode word on the previous edge");

   a_root_refresh : assert property (@(posedge clock) disable iff (reset)
      csr_wr_root |=> (refresh_ff && req_stall))
      else $error("root write not followed by a stalled refresh cycle");

   a_error_symbol_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == htbd_pkg::STATUS_ERROR)) |-> (rsp_symbol == '0))
      else $error("error response carries a nonzero symbol");

endmodule

`default_nettype wire
